>>> design/psma_pkg.sv
// Shared constants and types for the power sensor moving average block.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package psma_pkg;

  // Configuration register word (all registers are 24 bits).
  typedef logic [23:0] cfg_word_t;

  // Configuration register indexes (byte address = 4 * index).
  localparam logic [1:0] REG_DIVIDER_RATIO = 2'd0;
  localparam logic [1:0] REG_CURRENT_GAIN  = 2'd1;
  localparam logic [1:0] REG_VOLTAGE_BIAS  = 2'd2;
  localparam logic [1:0] REG_CURRENT_BIAS  = 2'd3;

  // Register reset values.
  localparam cfg_word_t DIVIDER_RATIO_RST = 24'd720896;
  localparam cfg_word_t CURRENT_GAIN_RST  = 24'd992969;
  localparam cfg_word_t VOLTAGE_BIAS_RST  = 24'd0;
  localparam cfg_word_t CURRENT_BIAS_RST  = 24'd0;

  // Converter scaling: adc = (raw * ADC_GAIN + ADC_HALF) / ADC_DIV in Q16.16.
  // The division uses floor(2^ADC_RECIP_SHIFT / ADC_DIV) and one correction step.
  localparam logic [31:0] ADC_GAIN        = 32'd720896;
  localparam logic [31:0] ADC_HALF        = 32'd6825;
  localparam logic [31:0] ADC_DIV         = 32'd13650;
  localparam logic [31:0] ADC_RECIP       = 32'd1288804838;
  localparam int          ADC_RECIP_SHIFT = 44;
  localparam int          ADC_W           = 18;

  // Mid rail of the current sensor, 2.5 V in Q16.16.
  localparam logic signed [18:0] MID_RAIL = 19'sd163840;

  // Half an LSB of the Q16 fraction, for round-half-up.
  localparam logic [15:0] Q16_HALF = 16'h8000;

  // Number of stored samples below which the first sample is returned.
  localparam int EARLY_SLOTS = 3;

endpackage

`default_nettype wire

>>> design/psma_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module psma_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port: data appears in the cycle after rd_en.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> design/power_sensor_moving_average_top.sv
// Power sensor moving average: converter scaling, ring buffer averaging and power.
// Depends on psma_pkg and psma_ram.
`timescale 1ns / 1ps
`default_nettype none

// Each request carries one 12-bit converter reading and produces exactly one
// result of mean voltage, mean current and power, all signed Q16.16. The block
// works on one request at a time and runs a reciprocal multiply for the
// converter scaling, the gain multiplies, and a 32-step restoring divider
// (one quotient bit per cycle, voltage and current in parallel) that forms
// the window averages. While the early window returns the first stored
// sample no division runs. The next request can be accepted as soon as the
// result sits in the output register, even if it has not been taken yet.
// The two sample rings share one memory of SAMPLES entries with a registered
// read; its contents are undefined after reset and need no clearing pass,
// since read data is used only after its entry has been written. For
// configuration writes to take effect on the next request, the user must
// make them between requests; the block does not enforce this.
module power_sensor_moving_average_top
  import psma_pkg::*;
#(
  parameter int SAMPLES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [11:0] raw_sample
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [95:0]      out_tdata,  // [31:0] mean_voltage, [63:32] mean_current,
                                       // [95:64] power_watts
  // Configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int SLOT_W = $clog2(SAMPLES);
  localparam int CNT_W  = $clog2(SAMPLES + 1);
  localparam int TOT_W  = 32 + $clog2(SAMPLES);
  localparam int TOP_W  = TOT_W - 32;
  localparam int PV_W   = ADC_W + 24;
  localparam int PI_W   = ADC_W + 1 + 25;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RECIP = 4'd1;
  localparam logic [3:0] ST_ADC   = 4'd2;
  localparam logic [3:0] ST_MUL   = 4'd3;
  localparam logic [3:0] ST_SCALE = 4'd4;
  localparam logic [3:0] ST_PREP  = 4'd5;
  localparam logic [3:0] ST_DIV   = 4'd6;
  localparam logic [3:0] ST_SIGN  = 4'd7;
  localparam logic [3:0] ST_PWR   = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  logic [3:0]              state_r, state_nxt;
  logic [SLOT_W-1:0]       slot_r;
  logic                    ring_full_r;
  logic signed [TOT_W-1:0] tot_v_r, tot_i_r;

  cfg_word_t               divider_ratio_r, current_gain_r, voltage_bias_r, current_bias_r;

  logic [31:0]             num_r;
  logic [63:0]             adc_prod_r;
  logic [ADC_W-1:0]        adc_r;
  logic [PV_W-1:0]         pv_r;
  logic signed [PI_W-1:0]  pi_r;
  logic signed [31:0]      first_v_r, first_i_r;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        rem_v_r, rem_i_r;
  logic [31:0]             quo_v_r, quo_i_r;
  logic                    neg_v_r, neg_i_r;
  logic [4:0]              step_r;
  logic signed [31:0]      mv_r, mi_r;
  logic signed [63:0]      pwr_prod_r;
  logic                    out_tvalid_r;
  logic [95:0]             out_tdata_r;

  logic                    in_req;
  logic                    cfg_wr;
  logic                    ram_wr;
  logic [63:0]             ram_rdata;
  logic signed [31:0]      old_v, old_i;

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divider_ratio_r <= DIVIDER_RATIO_RST;
      current_gain_r  <= CURRENT_GAIN_RST;
      voltage_bias_r  <= VOLTAGE_BIAS_RST;
      current_bias_r  <= CURRENT_BIAS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_DIVIDER_RATIO: divider_ratio_r <= cfg_pwdata[23:0];
        REG_CURRENT_GAIN:  current_gain_r  <= cfg_pwdata[23:0];
        REG_VOLTAGE_BIAS:  voltage_bias_r  <= cfg_pwdata[23:0];
        REG_CURRENT_BIAS:  current_bias_r  <= cfg_pwdata[23:0];
        default:           divider_ratio_r <= divider_ratio_r;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_DIVIDER_RATIO: cfg_prdata = {8'd0, divider_ratio_r};
      REG_CURRENT_GAIN:  cfg_prdata = {8'd0, current_gain_r};
      REG_VOLTAGE_BIAS:  cfg_prdata = {8'd0, voltage_bias_r};
      REG_CURRENT_BIAS:  cfg_prdata = {8'd0, current_bias_r};
      default:           cfg_prdata = 32'd0;
    endcase
  end

  // ------------------------------------------------------------------
  // Sample ring: current in the upper half, voltage in the lower half
  // ------------------------------------------------------------------
  assign in_tready = (state_r == ST_IDLE);
  assign in_req    = in_tvalid & in_tready;
  assign ram_wr    = (state_r == ST_SCALE);

  logic signed [31:0] volts_nxt, amps_nxt;

  psma_ram #(
    .WIDTH (64),
    .DEPTH (SAMPLES)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (slot_r),
    .wr_data ({amps_nxt, volts_nxt}),
    .rd_en   (in_req),
    .rd_addr (slot_r),
    .rd_data (ram_rdata)
  );

  assign old_v = ram_rdata[31:0];
  assign old_i = ram_rdata[63:32];

  // ------------------------------------------------------------------
  // Datapath next values
  // ------------------------------------------------------------------
  logic [ADC_W-1:0]        q0;
  logic [31:0]             adc_rem;
  logic signed [ADC_W:0]   adc_centered;
  logic [PV_W:0]           pv_round;
  logic signed [PI_W:0]    pi_round;
  logic [SLOT_W-1:0]       slot_nxt;
  logic                    wrap;
  logic [CNT_W-1:0]        count_nxt;
  logic                    early;
  logic [TOT_W-1:0]        mag_v, mag_i;
  logic [CNT_W:0]          trial_v, trial_i;
  logic                    ge_v, ge_i;
  logic signed [64:0]      pwr_round;
  logic signed [48:0]      pwr_shift;
  logic [31:0]             pwr_sat;

  always_comb begin
    // Reciprocal quotient, then one correction step.
    q0      = adc_prod_r[ADC_RECIP_SHIFT +: ADC_W];
    adc_rem = num_r - (32'(q0) * ADC_DIV);

    // Converter reading centred on the current sensor mid rail.
    adc_centered = $signed({1'b0, adc_r}) - MID_RAIL;

    // Round half up and drop the 16 fraction bits, then add the biases.
    pv_round  = {1'b0, pv_r} + (PV_W + 1)'(Q16_HALF);
    pi_round  = {pi_r[PI_W-1], pi_r} + $signed((PI_W + 1)'(Q16_HALF));
    volts_nxt = $signed(32'(pv_round[PV_W:16]))
              + $signed({{8{voltage_bias_r[23]}}, voltage_bias_r});
    amps_nxt  = 32'($signed(pi_round[PI_W:16]))
              + $signed({{8{current_bias_r[23]}}, current_bias_r});

    // Ring position after this write.
    wrap     = (slot_r == SLOT_W'(SAMPLES - 1));
    slot_nxt = wrap ? '0 : slot_r + 1'b1;

    // Window length and the early-window case, taken after the write.
    count_nxt = ring_full_r ? CNT_W'(SAMPLES) : CNT_W'(slot_r);
    early     = !ring_full_r && (slot_r < SLOT_W'(EARLY_SLOTS));

    // Magnitudes with half the divisor added for round-half-away-from-zero.
    mag_v = (tot_v_r[TOT_W-1] ? TOT_W'(-tot_v_r) : TOT_W'(tot_v_r))
          + TOT_W'(count_nxt >> 1);
    mag_i = (tot_i_r[TOT_W-1] ? TOT_W'(-tot_i_r) : TOT_W'(tot_i_r))
          + TOT_W'(count_nxt >> 1);

    // One restoring divider step per lane.
    trial_v = {rem_v_r, quo_v_r[31]};
    trial_i = {rem_i_r, quo_i_r[31]};
    ge_v    = (trial_v >= {1'b0, count_r});
    ge_i    = (trial_i >= {1'b0, count_r});

    // Power: round half up, drop the fraction, saturate.
    pwr_round = {pwr_prod_r[63], pwr_prod_r} + $signed(65'(Q16_HALF));
    pwr_shift = pwr_round[64:16];
    if (pwr_shift > 49'sd2147483647) begin
      pwr_sat = 32'h7fff_ffff;
    end else if (pwr_shift < -49'sd2147483648) begin
      pwr_sat = 32'h8000_0000;
    end else begin
      pwr_sat = pwr_shift[31:0];
    end
  end

  // ------------------------------------------------------------------
  // Sequencer
  // ------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_req) state_nxt = ST_RECIP;
      ST_RECIP: state_nxt = ST_ADC;
      ST_ADC:   state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_PREP;
      ST_PREP:  state_nxt = early ? ST_PWR : ST_DIV;
      ST_DIV:   if (step_r == 5'd31) state_nxt = ST_SIGN;
      ST_SIGN:  state_nxt = ST_PWR;
      ST_PWR:   state_nxt = ST_OUT;
      ST_OUT:   if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      slot_r       <= '0;
      ring_full_r  <= 1'b0;
      tot_v_r      <= '0;
      tot_i_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Drop the entry that is about to be overwritten.
      if (state_r == ST_RECIP && ring_full_r) begin
        tot_v_r <= tot_v_r - TOT_W'(old_v);
        tot_i_r <= tot_i_r - TOT_W'(old_i);
      end

      // Add the new entry and advance the ring.
      if (state_r == ST_SCALE) begin
        tot_v_r <= tot_v_r + TOT_W'(volts_nxt);
        tot_i_r <= tot_i_r + TOT_W'(amps_nxt);
        slot_r  <= slot_nxt;
        if (wrap) ring_full_r <= 1'b1;
      end

      // Output register handshake.
      if (state_r == ST_OUT && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_req) num_r <= 32'(in_tdata[11:0]) * ADC_GAIN + ADC_HALF;
      end
      ST_RECIP: begin
        adc_prod_r <= 64'(num_r) * 64'(ADC_RECIP);
      end
      ST_ADC: begin
        adc_r <= (adc_rem >= ADC_DIV) ? q0 + 1'b1 : q0;
      end
      ST_MUL: begin
        pv_r <= PV_W'(adc_r) * PV_W'(divider_ratio_r);
        pi_r <= PI_W'(adc_centered) * $signed(PI_W'(current_gain_r));
      end
      ST_SCALE: begin
        if (!ring_full_r && slot_r == '0) begin
          first_v_r <= volts_nxt;
          first_i_r <= amps_nxt;
        end
      end
      ST_PREP: begin
        count_r <= count_nxt;
        neg_v_r <= tot_v_r[TOT_W-1];
        neg_i_r <= tot_i_r[TOT_W-1];
        rem_v_r <= CNT_W'(mag_v[TOT_W-1 -: TOP_W]);
        rem_i_r <= CNT_W'(mag_i[TOT_W-1 -: TOP_W]);
        quo_v_r <= mag_v[31:0];
        quo_i_r <= mag_i[31:0];
        step_r  <= 5'd0;
        mv_r    <= first_v_r;
        mi_r    <= first_i_r;
      end
      ST_DIV: begin
        rem_v_r <= ge_v ? CNT_W'(trial_v - {1'b0, count_r}) : CNT_W'(trial_v);
        rem_i_r <= ge_i ? CNT_W'(trial_i - {1'b0, count_r}) : CNT_W'(trial_i);
        quo_v_r <= {quo_v_r[30:0], ge_v};
        quo_i_r <= {quo_i_r[30:0], ge_i};
        step_r  <= step_r + 5'd1;
      end
      ST_SIGN: begin
        mv_r <= neg_v_r ? -$signed(quo_v_r) : $signed(quo_v_r);
        mi_r <= neg_i_r ? -$signed(quo_i_r) : $signed(quo_i_r);
      end
      ST_PWR: begin
        pwr_prod_r <= 64'(mv_r) * 64'(mi_r);
      end
      ST_OUT: begin
        if (!out_tvalid_r || out_tready) out_tdata_r <= {pwr_sat, mi_r, mv_r};
      end
      default: begin
        step_r <= step_r;
      end
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef ASSERT_OFF
  // Once the ring has wrapped it stays full until reset.
  assert property (@(posedge clk) disable iff (!rst_n)
    ring_full_r |=> ring_full_r)
    else $error("ring_full cleared without reset");

  // The ring becomes full exactly when the write position wraps to slot zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ring_full_r) |-> (slot_r == '0))
    else $error("ring_full set away from slot zero");

  // The divider remainder always stays below the window length.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_v_r < count_r && rem_i_r < count_r))
    else $error("divider remainder out of range");

  // No new request is taken while the ring is being written.
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr |-> !in_tready)
    else $error("request accepted during ring write");

  // A result is loaded only at the end of a request's sequence.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == ST_OUT))
    else $error("result loaded outside the output state");
`endif

endmodule

`default_nettype wire

>>> verif/psma_checker.sv
// Checker for the power sensor moving average block: watches the sample,
// result and register ports, predicts each result and compares it.
// Depends on psma_pkg for the register indexes, reset values and early-window size.
`timescale 1ns / 1ps

module psma_checker
  import psma_pkg::*;
#(
  parameter int RING_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [15:0] in_tdata,    // [11:0] raw_sample
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [95:0] out_tdata,   // [31:0] mean_voltage, [63:32] mean_current,
                                        // [95:64] power_watts
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  input  wire logic        cfg_pready,
  output int               mismatch_count,
  output int               pending_count,
  output int               result_count
);

  typedef struct packed {
    logic signed [31:0] mean_voltage;
    logic signed [31:0] mean_current;
    logic signed [31:0] power_watts;
  } reading_t;

  // Register copies, updated from observed writes.
  logic        [23:0] divider_ratio;
  logic        [23:0] current_gain;
  logic signed [23:0] voltage_bias;
  logic signed [23:0] current_bias;

  // Window state of the averaging rings.
  int     volt_ring [RING_DEPTH];
  int     amp_ring [RING_DEPTH];
  int     fill_slot;
  bit     ring_wrapped;
  longint volt_sum;
  longint amp_sum;

  reading_t averages_due[$];

  // Round to nearest with halves toward plus infinity, dropping 16 fraction bits.
  function automatic longint q16_round(longint p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  // Divide with rounding to nearest, halves away from zero.
  function automatic longint rounded_mean(longint total, longint count);
    if (total >= 0) return (total + count / 2) / count;
    return -((-total + count / 2) / count);
  endfunction

  // Scale one reading, push it into the rings and form the window averages.
  function automatic reading_t average_sample(logic [11:0] raw);
    longint   adc;
    longint   volts;
    longint   amps;
    longint   mv;
    longint   mi;
    longint   pw;
    int       slot;
    reading_t r;
    // 3.3 V over 4095 counts is 11/13650 V per count, kept in Q16.16.
    adc   = (longint'(raw) * 11 * 65536 + 6825) / 13650;
    volts = q16_round(adc * longint'(divider_ratio)) + longint'(voltage_bias);
    amps  = q16_round((adc - 163840) * longint'(current_gain)) + longint'(current_bias);
    slot  = fill_slot;
    if (ring_wrapped) begin
      volt_sum -= volt_ring[slot];
      amp_sum  -= amp_ring[slot];
    end
    volt_ring[slot] = int'(volts);
    amp_ring[slot]  = int'(amps);
    volt_sum += volts;
    amp_sum  += amps;
    fill_slot = (slot + 1) % RING_DEPTH;
    if (fill_slot == 0) ring_wrapped = 1'b1;
    // Too few samples for an average: the first stored sample stands in.
    if (!ring_wrapped && fill_slot < EARLY_SLOTS) begin
      mv = volt_ring[0];
      mi = amp_ring[0];
    end else begin
      mv = rounded_mean(volt_sum, ring_wrapped ? RING_DEPTH : fill_slot);
      mi = rounded_mean(amp_sum, ring_wrapped ? RING_DEPTH : fill_slot);
    end
    pw = q16_round(mv * mi);
    if (pw > 64'sd2147483647) pw = 64'sd2147483647;
    if (pw < -64'sd2147483648) pw = -64'sd2147483648;
    r.mean_voltage = 32'(mv);
    r.mean_current = 32'(mi);
    r.power_watts  = 32'(pw);
    return r;
  endfunction

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      if (mismatch_count < 10)
        $display("%0t: %s mismatch, expected %0d (0x%08h), got %0d (0x%08h)", $realtime,
                 field, $signed(want), want, $signed(got), got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      divider_ratio  = DIVIDER_RATIO_RST;
      current_gain   = CURRENT_GAIN_RST;
      voltage_bias   = VOLTAGE_BIAS_RST;
      current_bias   = CURRENT_BIAS_RST;
      fill_slot      = 0;
      ring_wrapped   = 1'b0;
      volt_sum       = 0;
      amp_sum        = 0;
      averages_due.delete();
      mismatch_count = 0;
      pending_count  = 0;
      result_count   = 0;
    end else begin
      // Register writes complete in the access cycle.
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_DIVIDER_RATIO: divider_ratio = cfg_pwdata[23:0];
          REG_CURRENT_GAIN:  current_gain  = cfg_pwdata[23:0];
          REG_VOLTAGE_BIAS:  voltage_bias  = cfg_pwdata[23:0];
          REG_CURRENT_BIAS:  current_bias  = cfg_pwdata[23:0];
          default: ;
        endcase
      end
      // Compare each taken result with the oldest prediction.
      if (out_tvalid && out_tready) begin
        if (averages_due.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: result 0x%024h arrived with no request outstanding", $realtime,
                     out_tdata);
          mismatch_count++;
        end else begin
          want = averages_due.pop_front();
          check_field("mean_voltage", want.mean_voltage, out_tdata[31:0]);
          check_field("mean_current", want.mean_current, out_tdata[63:32]);
          check_field("power_watts", want.power_watts, out_tdata[95:64]);
          result_count++;
        end
      end
      if (in_tvalid && in_tready) averages_due.push_back(average_sample(in_tdata[11:0]));
      pending_count = averages_due.size();
    end
  end

endmodule

>>> verif/power_sensor_moving_average_top_tb.sv
// Testbench top for the power sensor moving average block: drives samples and
// register settings with random idling and gives the verdict.
// Depends on psma_pkg, the block itself and psma_checker.
`timescale 1ns / 1ps

module power_sensor_moving_average_top_tb;
  import psma_pkg::*;

  localparam int SAMPLES         = 16;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int SETTLE_CYCLES   = 60;
  localparam int SETTING_COUNT   = 6;
  localparam int ITEMS_PER_SETTING = 305;
  localparam int DIRECTED_COUNT  = 20;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata    = '0;     // [11:0] raw_sample
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [95:0] out_tdata;            // [31:0] mean_voltage, [63:32] mean_current,
                                     // [95:64] power_watts
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int mismatch_count;
  int pending_count;
  int result_count;
  int cycle_count   = 0;
  int samples_sent  = 0;
  int tx_idle_pct   = 0;
  int rx_idle_pct   = 0;

  power_sensor_moving_average_top #(
    .SAMPLES(SAMPLES)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  psma_checker #(
    .RING_DEPTH(SAMPLES)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_pready    (cfg_pready),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count),
    .result_count  (result_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Result side stalls at random.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Hard stop if the block hangs.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
             pending_count);
    $display("Verification failed");
    $finish;
  end

  // One register write; psel stays high so writes can follow back to back.
  task automatic reg_write(logic [1:0] index, cfg_word_t value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {index, 2'b00};
    cfg_pwdata  <= {8'($urandom()), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  task automatic program_registers(cfg_word_t ratio, cfg_word_t gain, cfg_word_t v_bias,
                                   cfg_word_t i_bias);
    reg_write(REG_DIVIDER_RATIO, ratio);
    reg_write(REG_CURRENT_GAIN, gain);
    reg_write(REG_VOLTAGE_BIAS, v_bias);
    reg_write(REG_CURRENT_BIAS, i_bias);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Send one reading; tvalid is only lowered when an idle gap is taken.
  task automatic send_sample(logic [11:0] raw);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'h0, raw};
    do @(posedge clk); while (!in_tready);
    samples_sent++;
    // Idling scheme moves on with the sample count.
    if (samples_sent < 617) begin
      tx_idle_pct = 31;
      rx_idle_pct = 85;
    end else if (samples_sent < 1234) begin
      tx_idle_pct = 85;
      rx_idle_pct = 31;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  endtask

  // Stop sending and wait for every outstanding result, then a little more.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random reading, weighted toward the rails and the 2.5 V mid point.
  function automatic logic [11:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 12'd0;
      1:       return 12'd4095;
      2:       return 12'(3102 + $urandom_range(0, 4) - 2);
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  initial begin
    cfg_word_t   setting [SETTING_COUNT][4];
    logic [11:0] directed [DIRECTED_COUNT];
    // Reset values, extremes both ways, two random sets and reset values again.
    setting[0] = '{DIVIDER_RATIO_RST, CURRENT_GAIN_RST, VOLTAGE_BIAS_RST, CURRENT_BIAS_RST};
    setting[1] = '{24'hFFFFFF, 24'hFFFFFF, 24'h7FFFFF, 24'h800000};
    setting[2] = '{24'h000000, 24'h000000, 24'h800000, 24'h7FFFFF};
    setting[3] = '{24'($urandom()), 24'($urandom()), 24'($urandom()), 24'($urandom())};
    setting[4] = '{24'($urandom()), 24'($urandom()), 24'($urandom()), 24'($urandom())};
    setting[5] = '{DIVIDER_RATIO_RST, CURRENT_GAIN_RST, VOLTAGE_BIAS_RST, CURRENT_BIAS_RST};
    // Rails, mid rail, alternating bits; long enough to pass the early window,
    // the partial window and the first wrap of the ring.
    directed = '{12'd0, 12'd4095, 12'd3102, 12'd3103, 12'd2048, 12'd1, 12'd4094,
                 12'hAAA, 12'h555, 12'd0, 12'd4095, 12'd0, 12'd4095, 12'd3101,
                 12'd2047, 12'hFFF, 12'h800, 12'h7FF, 12'd0, 12'd4095};
    tx_idle_pct = 31;
    rx_idle_pct = 85;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int s = 0; s < SETTING_COUNT; s++) begin
      program_registers(setting[s][0], setting[s][1], setting[s][2], setting[s][3]);
      if (s == 0) begin
        foreach (directed[i]) send_sample(directed[i]);
      end
      for (int n = 0; n < ITEMS_PER_SETTING; n++) send_sample(pick_sample());
      drain_results();
    end

    $display("Sent %0d readings under %0d register settings, including both extremes,",
             samples_sent, SETTING_COUNT);
    $display("with sender and receiver stalls; %0d results compared, %0d mismatches.",
             result_count, mismatch_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
design/psma_pkg.sv
design/psma_ram.sv
design/power_sensor_moving_average_top.sv
verif/psma_checker.sv
verif/power_sensor_moving_average_top_tb.sv
